/* src/worklist_vertical_mac_conv_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the worklist MAC core
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef WORKLIST_VERTICAL_MAC_CONV_CORE_DEFINES_SVH
`define WORKLIST_VERTICAL_MAC_CONV_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WVMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WVMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/wvmc_pkg.sv */
// ----------------------------------------------------------------------------
// wvmc_pkg
// Types, codes and command/status bundles of the worklist MAC core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wvmc_pkg;

    localparam logic [2:0] OP_LOAD_ACT = 3'd0;
    localparam logic [2:0] OP_LOAD_WT  = 3'd1;
    localparam logic [2:0] OP_CLEAR    = 3'd2;
    localparam logic [2:0] OP_WORK     = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    localparam logic [2:0] REG_INPUT_STRIDE  = 3'd0;
    localparam logic [2:0] REG_WEIGHT_STRIDE = 3'd1;
    localparam logic [2:0] REG_IN_GROUPS     = 3'd2;
    localparam logic [2:0] REG_OUT_ELEMS     = 3'd3;
    localparam logic [2:0] REG_CGG           = 3'd4;

    typedef struct packed {
        logic [10:0] input_stride;
        logic [10:0] weight_stride;
        logic [3:0]  in_groups;
        logic [10:0] output_elements;
        logic [2:0]  conv_group_groups;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  group_group;
        logic [2:0]  in_group;
        logic [9:0]  element_address;
        logic [15:0] data_value;
        logic [2:0]  context_req;
        logic        first_in_list;
        logic [7:0]  out_delta;
        logic [7:0]  kernel_row;
        logic [7:0]  input_row;
        logic [7:0]  steps_minus_one;
    } item_t;

    typedef struct packed {
        logic take_item;
        logic exec;
        logic clear_step;
        logic step;
        logic write_back;
        logic capture_read;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       err;
        logic       clear_last;
        logic       steps_done;
        logic       pipe_empty;
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN,
        ST_WRITE,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

/* src/wvmc_ctrl.sv */
// ----------------------------------------------------------------------------
// wvmc_ctrl
// Sequencer: steps one item through decode, clear sweep, MAC run or read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wvmc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            out_free,
    input  wvmc_pkg::stat_t stat,
    output wvmc_pkg::cmd_t  cmd,
    output logic            in_ready
);
    import wvmc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (stat.err) begin
                    state_next = ST_DONE;
                end else begin
                    case (stat.opcode)
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_WORK:  state_next = ST_RUN;
                        OP_READ:  state_next = ST_READ;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (stat.clear_last) state_next = ST_DONE;
            end
            ST_RUN: begin
                if (stat.steps_done) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (stat.pipe_empty) state_next = ST_WRITE;
            end
            ST_WRITE: state_next = ST_DONE;
            ST_READ:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready      = 1'b1;
                cmd.take_item = in_valid;
            end
            ST_EXEC:  cmd.exec = 1'b1;
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_RUN:   cmd.step = 1'b1;
            ST_DRAIN: cmd = '0;
            ST_WRITE: cmd.write_back = 1'b1;
            ST_READ:  cmd.capture_read = 1'b1;
            ST_DONE:  cmd.emit = out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

/* src/wvmc_datapath.sv */
// ----------------------------------------------------------------------------
// wvmc_datapath
// Slot stores, accumulator store, range checks and the per-lane MAC pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wvmc_datapath #(
    parameter int LANES        = 4,
    parameter int ROWS         = 256,
    parameter int SLOTS        = 8,
    parameter int GROUP_GROUPS = 4,
    parameter int WORKERS      = 6
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  wvmc_pkg::cfg_t  cfg,
    input  wvmc_pkg::item_t item_in,
    input  wvmc_pkg::cmd_t  cmd,
    output wvmc_pkg::stat_t stat,
    output logic [47:0]     res_value,
    output logic [1:0]      res_status
);
    import wvmc_pkg::*;

    localparam int ELEMS  = ROWS * LANES;
    localparam int EW     = $clog2(ELEMS + 1);
    localparam int CBW    = $clog2(ELEMS + LANES + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int LW     = $clog2(LANES);
    localparam int AW     = $clog2(SLOTS * ROWS);
    localparam int ACW    = $clog2(GROUP_GROUPS * ROWS);
    localparam int WIDX   = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int RECIP  = (2 ** 20 + LANES - 1) / LANES;
    localparam logic signed [48:0] ACC_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] ACC_MIN = -ACC_MAX - 49'sd1;

    item_t item_reg;

    // Start row and strided end row must both fall inside the slot.
    function automatic logic span_ok(input logic [7:0] start, input logic [10:0] stride,
                                     input logic [7:0] last);
        logic signed [19:0] span;
        logic signed [20:0] fin;
        span = 20'($signed(stride) * $signed({1'b0, last}));
        fin  = $signed({13'd0, start}) + 21'(span);
        return (32'(start) < ROWS) && !fin[20] && (fin < 21'(ROWS));
    endfunction

    // ---------------- decode ----------------
    logic [5:0]      slot;
    logic            gg_ok, slot_ok, ctx_ok, off_ok, err;
    logic [29:0]     div_prod;
    logic [9:0]      addr_q;
    logic [LW-1:0]   addr_lane;
    logic [EW-1:0]   limit;
    logic [7:0]      run_prev, off;
    logic [7:0]      running_reg [WORKERS];

    always_comb begin
        gg_ok   = (32'(item_reg.group_group) < 32'(cfg.conv_group_groups))
               && (32'(item_reg.group_group) < GROUP_GROUPS);
        slot    = 6'(item_reg.group_group) * 6'(cfg.in_groups) + 6'(item_reg.in_group);
        slot_ok = gg_ok && (32'(item_reg.in_group) < 32'(cfg.in_groups))
               && (32'(slot) < SLOTS);
        div_prod  = 30'(32'(item_reg.element_address) * RECIP);
        addr_q    = div_prod[29:20];
        addr_lane = LW'(32'(item_reg.element_address) - 32'(addr_q) * LANES);
        limit     = (32'(cfg.output_elements) < ELEMS) ? EW'(cfg.output_elements)
                                                       : EW'(ELEMS);
        ctx_ok    = 32'(item_reg.context_req) < WORKERS;
        run_prev  = ctx_ok ? running_reg[WIDX'(item_reg.context_req)] : 8'd0;
        off       = item_reg.first_in_list ? item_reg.out_delta
                                           : run_prev + item_reg.out_delta;
        off_ok    = (32'(off) * LANES + LANES) <= 32'(limit);
        case (item_reg.opcode)
            OP_LOAD_ACT, OP_LOAD_WT:
                err = !slot_ok || !(32'(item_reg.element_address) < ELEMS);
            OP_CLEAR: err = !gg_ok;
            OP_WORK:
                err = !slot_ok || !ctx_ok || !off_ok
                   || !span_ok(item_reg.input_row, cfg.input_stride,
                               item_reg.steps_minus_one)
                   || !span_ok(item_reg.kernel_row, cfg.weight_stride,
                               item_reg.steps_minus_one);
            OP_READ: err = !gg_ok || !(32'(item_reg.element_address) < 32'(limit));
            default: err = 1'b1;
        endcase
    end

    logic [AW-1:0]  slot_elem_addr, act_start, wt_start;
    logic [ACW-1:0] gg_base;
    always_comb begin
        slot_elem_addr = AW'(32'(slot) * ROWS + 32'(addr_q));
        act_start      = AW'(32'(slot) * ROWS + 32'(item_reg.input_row));
        wt_start       = AW'(32'(slot) * ROWS + 32'(item_reg.kernel_row));
        gg_base        = ACW'(32'(item_reg.group_group) * ROWS);
    end

    logic exec_ok;
    assign exec_ok = cmd.exec && !err;

    // ---------------- slot stores ----------------
    logic [LANES-1:0][15:0] act_mem [SLOTS * ROWS];
    logic [LANES-1:0][15:0] wt_mem  [SLOTS * ROWS];
    logic [LANES-1:0][15:0] act_rdata_reg, wt_rdata_reg;
    logic [AW-1:0]          act_addr_reg, act_addr_next, wt_addr_reg, wt_addr_next;

    always_ff @(posedge aclk) begin
        if (exec_ok && item_reg.opcode == OP_LOAD_ACT) begin
            act_mem[slot_elem_addr][addr_lane] <= item_reg.data_value;
        end
        act_rdata_reg <= act_mem[act_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (exec_ok && item_reg.opcode == OP_LOAD_WT) begin
            wt_mem[slot_elem_addr][addr_lane] <= item_reg.data_value;
        end
        wt_rdata_reg <= wt_mem[wt_addr_reg];
    end

    // ---------------- accumulator store ----------------
    logic [LANES-1:0][47:0] acc_mem [GROUP_GROUPS * ROWS];
    logic [LANES-1:0][47:0] acc_rdata_reg, acc_wdata;
    logic [LANES-1:0]       acc_we;
    logic [ACW-1:0]         acc_raddr, acc_waddr;
    logic [ROW_W-1:0]       clr_row_reg, clr_row_next;
    logic [CBW-1:0]         clr_base_reg, clr_base_next;
    logic [7:0]             off_reg, off_next;
    logic [LANES-1:0][47:0] acc_work_reg, acc_work_next;

    assign acc_raddr = gg_base + ((item_reg.opcode == OP_READ) ? ACW'(addr_q) : ACW'(off));

    always_comb begin
        acc_we    = '0;
        acc_waddr = gg_base + ACW'(clr_row_reg);
        acc_wdata = '0;
        if (cmd.clear_step) begin
            for (int l = 0; l < LANES; l++) begin
                acc_we[l] = (32'(clr_base_reg) + l) < 32'(limit);
            end
        end else if (cmd.write_back) begin
            acc_we    = '1;
            acc_waddr = gg_base + ACW'(off_reg);
            acc_wdata = acc_work_reg;
        end
    end

    always_ff @(posedge aclk) begin
        for (int l = 0; l < LANES; l++) begin
            if (acc_we[l]) acc_mem[acc_waddr][l] <= acc_wdata[l];
        end
        acc_rdata_reg <= acc_mem[acc_raddr];
    end

    assign stat.clear_last = (32'(clr_base_reg) + LANES) >= 32'(limit);

    // ---------------- MAC pipeline ----------------
    logic [7:0]             steps_reg, steps_next;
    logic                   v1_reg, v2_reg, acc_load_reg, sat_reg, sat_next;
    logic [LANES-1:0][31:0] prod_reg;
    logic signed [48:0]     sum;

    always_comb begin
        act_addr_next = act_addr_reg;
        wt_addr_next  = wt_addr_reg;
        steps_next    = steps_reg;
        clr_row_next  = clr_row_reg;
        clr_base_next = clr_base_reg;
        off_next      = off_reg;
        if (exec_ok && item_reg.opcode == OP_WORK) begin
            act_addr_next = act_start;
            wt_addr_next  = wt_start;
            steps_next    = item_reg.steps_minus_one;
            off_next      = off;
        end else if (cmd.step) begin
            act_addr_next = act_addr_reg + AW'(32'($signed(cfg.input_stride)));
            wt_addr_next  = wt_addr_reg + AW'(32'($signed(cfg.weight_stride)));
            steps_next    = steps_reg - 8'd1;
        end
        if (exec_ok && item_reg.opcode == OP_CLEAR) begin
            clr_row_next  = '0;
            clr_base_next = '0;
        end else if (cmd.clear_step) begin
            clr_row_next  = clr_row_reg + ROW_W'(1);
            clr_base_next = clr_base_reg + CBW'(LANES);
        end
    end

    // Saturating accumulation, one product per lane per cycle.
    always_comb begin
        acc_work_next = acc_work_reg;
        sat_next      = sat_reg;
        sum           = '0;
        if (exec_ok && item_reg.opcode == OP_WORK) begin
            sat_next = 1'b0;
        end else if (acc_load_reg) begin
            acc_work_next = acc_rdata_reg;
        end else if (v2_reg) begin
            for (int l = 0; l < LANES; l++) begin
                sum = 49'($signed(acc_work_reg[l])) + 49'($signed(prod_reg[l]));
                if (sum > ACC_MAX) begin
                    acc_work_next[l] = ACC_MAX[47:0];
                    sat_next         = 1'b1;
                end else if (sum < ACC_MIN) begin
                    acc_work_next[l] = ACC_MIN[47:0];
                    sat_next         = 1'b1;
                end else begin
                    acc_work_next[l] = sum[47:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int l = 0; l < LANES; l++) begin
            prod_reg[l] <= 32'($signed(act_rdata_reg[l]) * $signed(wt_rdata_reg[l]));
        end
        act_addr_reg <= act_addr_next;
        wt_addr_reg  <= wt_addr_next;
        steps_reg    <= steps_next;
        clr_row_reg  <= clr_row_next;
        clr_base_reg <= clr_base_next;
        off_reg      <= off_next;
        acc_work_reg <= acc_work_next;
        if (cmd.take_item) item_reg <= item_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            acc_load_reg <= 1'b0;
            sat_reg      <= 1'b0;
            for (int w = 0; w < WORKERS; w++) running_reg[w] <= 8'd0;
        end else begin
            v1_reg       <= cmd.step;
            v2_reg       <= v1_reg;
            acc_load_reg <= exec_ok && item_reg.opcode == OP_WORK;
            sat_reg      <= sat_next;
            if (exec_ok && item_reg.opcode == OP_WORK) begin
                running_reg[WIDX'(item_reg.context_req)] <= off;
            end
        end
    end

    assign stat.steps_done = steps_reg == 8'd0;
    assign stat.pipe_empty = !v1_reg && !v2_reg;
    assign stat.opcode     = item_reg.opcode;
    assign stat.err        = err;

    // ---------------- result ----------------
    logic [47:0] res_value_reg;
    logic [1:0]  res_status_reg;

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_value_reg  <= '0;
            res_status_reg <= err ? STATUS_RANGE : STATUS_OK;
        end else if (cmd.capture_read) begin
            res_value_reg <= acc_rdata_reg[addr_lane];
        end else if (cmd.write_back && sat_reg) begin
            res_status_reg <= STATUS_SAT;
        end
    end

    assign res_value  = res_value_reg;
    assign res_status = res_status_reg;

endmodule

/* src/worklist_vertical_mac_conv_core.sv */
// ----------------------------------------------------------------------------
// worklist_vertical_mac_conv_core
// Worklist-driven grouped 1x1 convolution multiply-accumulate engine.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_ stream, the opcode in s_tuser and all other fields
// in s_tdata. Every item yields exactly one result transfer on the m_ stream
// carrying the 48-bit accumulator (reads only, zero otherwise) and a status.
// Registers are written over the cfg_ channel, which is always ready; write
// them only while no item is in flight.
// One item is processed at a time. A load or a rejected item passes from
// decode straight to the output register; a read first captures the
// addressed accumulator lane. A clear sweeps one accumulator row per cycle.
// A work entry issues one strided step per cycle through the wide slot-store
// read port and a multiply / accumulate pipeline, then drains and writes back.
// The next item is accepted once the previous one has left the sequencer,
// even while its result still waits in the output register.
// Reset clears the sequencer, the running offsets and the output valid;
// slot and accumulator stores hold no defined value until loaded or cleared.
// If the receiver stalls, the result holds in the output register and the
// sequencer waits in its final state until the register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "worklist_vertical_mac_conv_core_defines.svh"

module worklist_vertical_mac_conv_core #(
    parameter int LANES        = 4,
    parameter int ROWS         = 256,
    parameter int SLOTS        = 8,
    parameter int GROUP_GROUPS = 4,
    parameter int WORKERS      = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // group_group[1:0], in_group[4:2], element_address[14:5], data_value[30:15],
    // context_req[33:31], first_in_list[34], out_delta[42:35], kernel_row[50:43],
    // input_row[58:51], steps_minus_one[66:59], zero fill [71:67]
    input  logic [71:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // output_value[47:0], status[49:48], zero fill [55:50]
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import wvmc_pkg::*;

    // Configuration registers; any index past the list is accepted and dropped.
    cfg_t cfg_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.input_stride      <= 11'd1;
            cfg_reg.weight_stride     <= 11'd1;
            cfg_reg.in_groups         <= 4'd1;
            cfg_reg.output_elements   <= 11'd1024;
            cfg_reg.conv_group_groups <= 3'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_INPUT_STRIDE:  cfg_reg.input_stride      <= cfg_data[10:0];
                REG_WEIGHT_STRIDE: cfg_reg.weight_stride     <= cfg_data[10:0];
                REG_IN_GROUPS:     cfg_reg.in_groups         <= cfg_data[3:0];
                REG_OUT_ELEMS:     cfg_reg.output_elements   <= cfg_data[10:0];
                REG_CGG:           cfg_reg.conv_group_groups <= cfg_data[2:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Unpack the incoming transfer into the item bundle.
    item_t item_in;
    always_comb begin
        item_in.opcode          = s_tuser;
        item_in.group_group     = s_tdata[1:0];
        item_in.in_group        = s_tdata[4:2];
        item_in.element_address = s_tdata[14:5];
        item_in.data_value      = s_tdata[30:15];
        item_in.context_req     = s_tdata[33:31];
        item_in.first_in_list   = s_tdata[34];
        item_in.out_delta       = s_tdata[42:35];
        item_in.kernel_row      = s_tdata[50:43];
        item_in.input_row       = s_tdata[58:51];
        item_in.steps_minus_one = s_tdata[66:59];
    end

    cmd_t        cmd;
    stat_t       stat;
    logic [47:0] res_value;
    logic [1:0]  res_status;
    logic        out_free;

    // Output register: free when empty or being drained this cycle.
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    wvmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    wvmc_datapath #(
        .LANES        (LANES),
        .ROWS         (ROWS),
        .SLOTS        (SLOTS),
        .GROUP_GROUPS (GROUP_GROUPS),
        .WORKERS      (WORKERS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_in    (item_in),
        .cmd        (cmd),
        .stat       (stat),
        .res_value  (res_value),
        .res_status (res_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) m_tdata_reg <= {6'd0, res_status, res_value};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Fields of the outgoing transfer, named for the checks below.
    logic [1:0]  m_status;
    logic [47:0] m_value;
    logic        m_reject;
    assign m_status = m_tdata[49:48];
    assign m_value  = m_tdata[47:0];
    assign m_reject = m_tvalid && m_status == STATUS_RANGE;

    // One item in the sequencer at a time.
    `WVMC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken early")
    // Only defined status codes are ever delivered.
    `WVMC_ASSERT_NOW(a_status_code, m_tvalid, m_status <= STATUS_SAT, "undefined status code")
    // A rejected item never carries accumulator data.
    `WVMC_ASSERT_NOW(a_err_zero, m_reject, m_value == '0, "rejected item with data")

endmodule
